### rtl/core/iar_pkg.sv
// ----------------------------------------------------------------------------
// iar_pkg: shared definitions for the integer to ASCII radix unit
// Widths, digit counts, character codes, state and operation encodings.
// ----------------------------------------------------------------------------
package iar_pkg;

   // Converted width and the fixed width of the input value port.
   localparam int VALUE_BITS = 32;
   localparam int IN_BITS    = 32;

   // Digit counts of the widest value in each radix.
   localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;

   localparam int MAX_DH     = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int NSLOT      = (MAX_DH > OCT_DIGITS) ? MAX_DH : OCT_DIGITS;
   localparam int DEC_BASE   = NSLOT - DEC_DIGITS;

   localparam int STEP_W     = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int REM_W      = $clog2(NSLOT + 1);

   // ASCII codes.
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CHAR_O       = 8'h6F;

   typedef enum logic [1:0] {
      MODE_UDEC = 2'd0,
      MODE_SDEC = 2'd1,
      MODE_HEX  = 2'd2,
      MODE_OCT  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_NEG,
      ST_DABBLE,
      ST_SKIP,
      ST_PFX0,
      ST_PFX1,
      ST_DIG
   } state_type;

   typedef enum logic [1:0] {
      MAG_HOLD,
      MAG_LOAD,
      MAG_NEG,
      MAG_SHIFT
   } mag_op_type;

   typedef enum logic [2:0] {
      DIG_HOLD,
      DIG_LOAD_HEX,
      DIG_LOAD_OCT,
      DIG_CLEAR,
      DIG_DABBLE,
      DIG_SHIFT
   } dig_op_type;

   function automatic logic [7:0] digit_char(input logic [3:0] digit);
      if (digit < 4'd10) begin
         return CHAR_ZERO + {4'd0, digit};
      end
      return CHAR_UPPER_A + {4'd0, digit} - 8'd10;
   endfunction

endpackage

### rtl/core/iar_mag.sv
// ----------------------------------------------------------------------------
// iar_mag: magnitude shift register
// Loads the value, forms the two's complement one bit per cycle and
// shifts the magnitude out most significant bit first.
// ----------------------------------------------------------------------------
module iar_mag
   import iar_pkg::*;
(
   input  logic                  clock,
   input  mag_op_type            mag_op,
   input  logic [IN_BITS-1:0]    load_value,
   output logic [VALUE_BITS-1:0] mag_bits,
   output logic                  mag_msb
);

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  seen_ff, seen_in;
   logic [VALUE_BITS-1:0] load_ext;

   always_comb begin
      for (int i = 0; i < VALUE_BITS; i++) begin
         load_ext[i] = (i < IN_BITS) ? load_value[i] : 1'b0;
      end
   end

   // Serial negate: keep bits up to the first one, invert the rest.
   always_comb begin
      mag_in  = mag_ff;
      seen_in = seen_ff;
      case (mag_op)
         MAG_LOAD: begin
            mag_in  = load_ext;
            seen_in = 1'b0;
         end
         MAG_NEG: begin
            mag_in  = {mag_ff[0] ^ seen_ff, mag_ff[VALUE_BITS-1:1]};
            seen_in = seen_ff | mag_ff[0];
         end
         MAG_SHIFT: begin
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         end
         default: begin
            mag_in = mag_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      seen_ff <= seen_in;
   end

   assign mag_bits = mag_ff;
   assign mag_msb  = mag_ff[VALUE_BITS-1];

endmodule

### rtl/core/iar_digits.sv
// ----------------------------------------------------------------------------
// iar_digits: digit register
// Holds the digits top aligned; builds decimal digits by shift-and-add-3,
// loads hex and octal digits directly, and shifts digits out from the top.
// ----------------------------------------------------------------------------
module iar_digits
   import iar_pkg::*;
(
   input  logic                  clock,
   input  dig_op_type            dig_op,
   input  logic [VALUE_BITS-1:0] load_bits,
   input  logic                  serial_bit,
   output logic [3:0]            top_digit
);

   logic [3:0] slot_ff [NSLOT];
   logic [3:0] slot_in [NSLOT];
   logic [3:0] corr    [NSLOT];
   logic [3:0] hex_load[NSLOT];
   logic [3:0] oct_load[NSLOT];

   always_comb begin
      int k;
      int pos;
      for (int s = 0; s < NSLOT; s++) begin
         corr[s] = (slot_ff[s] >= 4'd5) ? slot_ff[s] + 4'd3 : slot_ff[s];
         k = NSLOT - 1 - s;
         for (int b = 0; b < 4; b++) begin
            hex_load[s][b] = 1'b0;
            oct_load[s][b] = 1'b0;
            if (k < HEX_DIGITS) begin
               pos = (HEX_DIGITS - 1 - k) * 4 + b;
               if (pos < VALUE_BITS) begin
                  hex_load[s][b] = load_bits[pos];
               end
            end
            if (k < OCT_DIGITS && b < 3) begin
               pos = (OCT_DIGITS - 1 - k) * 3 + b;
               if (pos < VALUE_BITS) begin
                  oct_load[s][b] = load_bits[pos];
               end
            end
         end
      end
   end

   always_comb begin
      for (int s = 0; s < NSLOT; s++) begin
         slot_in[s] = slot_ff[s];
      end
      case (dig_op)
         DIG_LOAD_HEX: begin
            for (int s = 0; s < NSLOT; s++) begin
               slot_in[s] = hex_load[s];
            end
         end
         DIG_LOAD_OCT: begin
            for (int s = 0; s < NSLOT; s++) begin
               slot_in[s] = oct_load[s];
            end
         end
         DIG_CLEAR: begin
            for (int s = 0; s < NSLOT; s++) begin
               slot_in[s] = 4'd0;
            end
         end
         DIG_DABBLE: begin
            // correct every BCD digit, then shift the next bit in at the base
            for (int s = 0; s < NSLOT; s++) begin
               if (s == DEC_BASE) begin
                  slot_in[s] = {corr[s][2:0], serial_bit};
               end else if (s > DEC_BASE) begin
                  slot_in[s] = {corr[s][2:0], corr[s-1][3]};
               end
            end
         end
         DIG_SHIFT: begin
            for (int s = NSLOT - 1; s > 0; s--) begin
               slot_in[s] = slot_ff[s-1];
            end
            slot_in[0] = 4'd0;
         end
         default: begin
            for (int s = 0; s < NSLOT; s++) begin
               slot_in[s] = slot_ff[s];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NSLOT; s++) begin
         slot_ff[s] <= slot_in[s];
      end
   end

   assign top_digit = slot_ff[NSLOT-1];

endmodule

### rtl/core/integer_to_ascii_radix_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_unit: binary to ASCII text converter
// Turns one number into its decimal, signed decimal, hex or octal text,
// one character per result beat, most significant digit first.
// ----------------------------------------------------------------------------
// The unit takes one number at a time: req_stall stays high from the beat
// after acceptance until the final character has been handed to the output
// register. Mode 0 prints unsigned decimal, mode 1 signed decimal with a
// leading '-', mode 2 hex as "0x" plus upper-case digits and mode 3 octal as
// "0o" plus digits; zero prints a single '0' digit. rsp_last marks the final
// character. Decimal digits come out of a bit-serial shift-and-add-3
// converter that takes one magnitude bit per cycle, after a negative
// value has been negated serially; hex and octal digits load directly.
// Leading zeros are then suppressed one per cycle, keeping at least one
// digit, before the characters go out. Output back-pressure holds the
// unit; one result waits in the output register while the next character
// is prepared.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_unit
   import iar_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_action,
   input  logic [31:0]  req_value,

   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_char_out,
   output logic         rsp_last
);

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic                 neg_ff, neg_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [REM_W-1:0]     rem_ff, rem_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   mag_op_type           mag_op;
   dig_op_type           dig_op;
   logic [VALUE_BITS-1:0] mag_bits;
   logic                 mag_msb;
   logic [3:0]           top_digit;

   logic                 out_free;
   logic                 emit;
   logic [7:0]           emit_char;
   logic                 emit_last;
   logic                 radix_mode;
   logic                 more_zeros;

   iar_mag u_mag (
      .clock      (clock),
      .mag_op     (mag_op),
      .load_value (req_value),
      .mag_bits   (mag_bits),
      .mag_msb    (mag_msb)
   );

   iar_digits u_digits (
      .clock      (clock),
      .dig_op     (dig_op),
      .load_bits  (mag_bits),
      .serial_bit (mag_msb),
      .top_digit  (top_digit)
   );

   // Output register frees up when empty or when its beat is taken.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign radix_mode = (mode_ff == MODE_HEX) || (mode_ff == MODE_OCT);
   assign more_zeros = (top_digit == 4'd0) && (rem_ff > REM_W'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            case (mode_ff)
               MODE_HEX, MODE_OCT: state_in = ST_SKIP;
               MODE_SDEC:          state_in = mag_msb ? ST_NEG : ST_DABBLE;
               default:            state_in = ST_DABBLE;
            endcase
         end
         ST_NEG: begin
            if (step_ff == '0) begin
               state_in = ST_DABBLE;
            end
         end
         ST_DABBLE: begin
            if (step_ff == '0) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!more_zeros) begin
               state_in = (radix_mode || neg_ff) ? ST_PFX0 : ST_DIG;
            end
         end
         ST_PFX0: begin
            if (out_free) begin
               state_in = radix_mode ? ST_PFX1 : ST_DIG;
            end
         end
         ST_PFX1: begin
            if (out_free) begin
               state_in = ST_DIG;
            end
         end
         ST_DIG: begin
            if (out_free && rem_ff == REM_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath control per state.
   always_comb begin
      mag_op    = MAG_HOLD;
      dig_op    = DIG_HOLD;
      mode_in   = mode_ff;
      neg_in    = neg_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      emit      = 1'b0;
      emit_char = CHAR_ZERO;
      emit_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mag_op  = MAG_LOAD;
               mode_in = mode_type'(req_action);
               neg_in  = 1'b0;
            end
         end
         ST_SETUP: begin
            step_in = STEP_W'(VALUE_BITS - 1);
            case (mode_ff)
               MODE_HEX: begin
                  dig_op = DIG_LOAD_HEX;
                  rem_in = REM_W'(HEX_DIGITS);
               end
               MODE_OCT: begin
                  dig_op = DIG_LOAD_OCT;
                  rem_in = REM_W'(OCT_DIGITS);
               end
               default: begin
                  dig_op = DIG_CLEAR;
                  rem_in = REM_W'(DEC_DIGITS);
                  neg_in = (mode_ff == MODE_SDEC) && mag_msb;
               end
            endcase
         end
         ST_NEG: begin
            mag_op  = MAG_NEG;
            step_in = (step_ff == '0) ? STEP_W'(VALUE_BITS - 1) : step_ff - 1'b1;
         end
         ST_DABBLE: begin
            mag_op  = MAG_SHIFT;
            dig_op  = DIG_DABBLE;
            step_in = step_ff - 1'b1;
         end
         ST_SKIP: begin
            // drop one leading zero per cycle, keep at least one digit
            if (more_zeros) begin
               dig_op = DIG_SHIFT;
               rem_in = rem_ff - 1'b1;
            end
         end
         ST_PFX0: begin
            emit      = 1'b1;
            emit_char = radix_mode ? CHAR_ZERO : CHAR_MINUS;
         end
         ST_PFX1: begin
            emit      = 1'b1;
            emit_char = (mode_ff == MODE_HEX) ? CHAR_X : CHAR_O;
         end
         ST_DIG: begin
            emit      = 1'b1;
            emit_char = digit_char(top_digit);
            emit_last = (rem_ff == REM_W'(1));
            if (out_free) begin
               dig_op = DIG_SHIFT;
               rem_in = rem_ff - 1'b1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Output register: advance when free, hold while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      rem_ff      <= rem_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

### rtl/core/iar_checker.sv
// ----------------------------------------------------------------------------
// iar_checker: port-level checks for the integer to ASCII radix unit
// Watches the request and response ports and is bound to the top level.
// ----------------------------------------------------------------------------
module iar_checker
   import iar_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic [1:0]   req_action,
   input logic [31:0]  req_value,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input logic [7:0]   rsp_char_out,
   input logic         rsp_last
);

   // An accepted number keeps the input side busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not held off after a number was accepted");

   // A stalled request beat holds.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_action) && $stable(req_value))
      else $error("stalled request beat changed");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_out) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // Only digits, sign and prefix letters are ever produced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_char_out >= CHAR_ZERO && rsp_char_out <= CHAR_NINE) ||
         (rsp_char_out >= CHAR_UPPER_A && rsp_char_out <= CHAR_UPPER_F) ||
         rsp_char_out == CHAR_MINUS || rsp_char_out == CHAR_X ||
         rsp_char_out == CHAR_O)
      else $error("unexpected character on result");

   // A sign or prefix letter is never the final character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_char_out == CHAR_MINUS || rsp_char_out == CHAR_X ||
                    rsp_char_out == CHAR_O) |-> !rsp_last)
      else $error("sign or prefix flagged as final character");

endmodule

bind integer_to_ascii_radix_unit iar_checker u_iar_checker (.*);

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for integer_to_ascii_radix_unit
// Feeds numbers in all four print modes and compares every character beat
// against text rendered independently in the bench.
// ----------------------------------------------------------------------------
module testbench
   import iar_pkg::*;
();

   // One number to print and the mode to print it in.
   typedef struct {
      mode_type    action;
      logic [31:0] value;
   } number_item_type;

   // One character beat of the rendered text.
   typedef struct {
      logic [7:0] char_code;
      logic       last;
   } text_char_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_valid  = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = 2'd0;
   logic [31:0] req_value  = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall  = 1'b0;
   logic [7:0]  rsp_char_out;
   logic        rsp_last;

   number_item_type pending_numbers[$];   // numbers not yet presented on req_
   text_char_type   expected_text[$];     // characters still owed by the unit
   number_item_type next_number;
   int          numbers_taken  = 0;
   int          chars_seen     = 0;
   int          mismatch_count = 0;

   integer_to_ascii_radix_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Render one number as text and append its characters to expected_text.
   // Digits are produced least significant first, then emitted in reverse.
   function automatic void render_number(mode_type action, logic [31:0] value);
      logic [7:0]  text [0:15];
      logic [7:0]  digit_buf [0:15];
      logic [31:0] mag;
      logic [31:0] radix;
      logic [3:0]  digit;
      int          len;
      int          ndig;
      text_char_type beat;
      len  = 0;
      ndig = 0;
      mag  = value;
      case (action)
         MODE_UDEC: begin
            radix = 32'd10;
         end
         MODE_SDEC: begin
            radix = 32'd10;
            // Negate in 32-bit unsigned so the most negative value stays exact.
            if (value[31]) begin
               text[len] = "-";
               len = len + 1;
               mag = 32'd0 - value;
            end
         end
         MODE_HEX: begin
            radix = 32'd16;
            text[0] = "0";
            text[1] = "x";
            len = 2;
         end
         default: begin
            radix = 32'd8;
            text[0] = "0";
            text[1] = "o";
            len = 2;
         end
      endcase
      // Zero still yields one '0' digit.
      do begin
         digit = 4'(mag % radix);
         digit_buf[ndig] = (digit < 4'd10) ? (8'h30 + 8'(digit)) : (8'h41 + 8'(digit) - 8'd10);
         ndig = ndig + 1;
         mag = mag / radix;
      end while (mag != 32'd0);
      while (ndig > 0) begin
         ndig = ndig - 1;
         text[len] = digit_buf[ndig];
         len = len + 1;
      end
      for (int k = 0; k < len; k++) begin
         beat.char_code = text[k];
         beat.last      = (k == len - 1);
         expected_text.push_back(beat);
      end
   endfunction

   // Driver: present one number per beat, hold it while stalled, and render
   // the expected text at the edge where the unit takes it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            render_number(mode_type'(req_action), req_value);
            numbers_taken = numbers_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            // Idle at random, except for a calm stretch in the middle of the run.
            if (pending_numbers.size() != 0 &&
                ((numbers_taken >= 60 && numbers_taken < 90) ||
                 $urandom_range(0, 99) >= 37)) begin
               next_number = pending_numbers.pop_front();
               req_valid  <= 1'b1;
               req_action <= next_number.action;
               req_value  <= next_number.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted character beat with the oldest expected
   // one, then pick the stall for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            chars_seen = chars_seen + 1;
            if (expected_text.size() == 0) begin
               $error("unexpected beat: char_out %h last %b with nothing expected",
                      rsp_char_out, rsp_last);
               mismatch_count = mismatch_count + 1;
            end else begin
               if (rsp_char_out !== expected_text[0].char_code) begin
                  $error("char_out: expected %h got %h",
                         expected_text[0].char_code, rsp_char_out);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_last !== expected_text[0].last) begin
                  $error("last: expected %b got %b", expected_text[0].last, rsp_last);
                  mismatch_count = mismatch_count + 1;
               end
               expected_text.pop_front();
            end
         end
         // Hold stall low through a calm stretch of the output stream.
         rsp_stall <= !(chars_seen >= 400 && chars_seen < 700) &&
                      ($urandom_range(0, 99) < 37);
      end
   end

   // Stimulus and end of run.
   initial begin
      number_item_type item;
      logic [31:0] edge_values [0:3];
      edge_values[0] = 32'h0000_0000;
      edge_values[1] = 32'hFFFF_FFFF;
      edge_values[2] = 32'h8000_0000;
      edge_values[3] = 32'h7FFF_FFFF;

      // Directed: every mode against zero, all ones, most negative and most
      // positive, then a few numbers that hit every digit and digit-count edges.
      for (int m = 0; m < 4; m++) begin
         for (int e = 0; e < 4; e++) begin
            item.action = mode_type'(m);
            item.value  = edge_values[e];
            pending_numbers.push_back(item);
         end
      end
      item.action = MODE_HEX;  item.value = 32'hFEDC_BA98; pending_numbers.push_back(item);
      item.action = MODE_HEX;  item.value = 32'h0123_4567; pending_numbers.push_back(item);
      item.action = MODE_OCT;  item.value = 32'h0053_977F; pending_numbers.push_back(item);
      item.action = MODE_SDEC; item.value = 32'd1;         pending_numbers.push_back(item);
      item.action = MODE_UDEC; item.value = 32'd9;         pending_numbers.push_back(item);
      item.action = MODE_UDEC; item.value = 32'd10;        pending_numbers.push_back(item);
      item.action = MODE_SDEC; item.value = 32'hFFFF_FFF6; pending_numbers.push_back(item);

      // Random: mix full-width values with small, single-bit and near-extreme
      // ones so that every digit count shows up.
      for (int n = 0; n < 107; n++) begin
         item.action = mode_type'($urandom_range(0, 3));
         case ($urandom_range(0, 4))
            0: item.value = $urandom;
            1: item.value = $urandom_range(0, 255);
            2: item.value = 32'h1 << $urandom_range(0, 31);
            3: item.value = 32'h8000_0000 + $urandom_range(0, 15);
            default: item.value = 32'hFFFF_FFFF - $urandom_range(0, 15);
         endcase
         pending_numbers.push_back(item);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Drain: wait until every number is taken and every character seen.
      while (pending_numbers.size() != 0 || req_valid || expected_text.size() != 0) begin
         @(posedge clock);
      end
      // Let any stray beats surface before deciding.
      repeat (100) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #(12 * 400000);
      $display("testbench failed");
      $finish;
   end

endmodule
